FILE: design/rdmm_pkg.sv
// rdmm_pkg: shared types and constants for the reversible min/max deque
// holds the operation and status codes, the beat structs and the control states
// no dependencies
package rdmm_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int WORD_W        = 32;
   localparam int COUNT_W       = 7;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_REVERSE    = 3'd4,
      OP_QUERY      = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_FULL       = 2'd1,
      ST_EMPTY      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]               operation;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] back_value;
      logic [COUNT_W-1:0]       count;
      logic signed [WORD_W-1:0] largest;
      logic signed [WORD_W-1:0] smallest;
      logic                     is_empty;
      logic [1:0]               status;
   } rsp_type;

endpackage

FILE: design/rdmm_ram.sv
// rdmm_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module rdmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/reversible_deque_min_max_top.sv
// reversible_deque_min_max_top: bounded deque of signed words in a ring buffer with min/max
// depends on rdmm_pkg and rdmm_ram
//
//   channel   direction   beat type            handshake
//   req_      in          rdmm_pkg::req_type   req_valid / req_stall
//   rsp_      out         rdmm_pkg::rsp_type   rsp_valid / rsp_stall
//
// one request beat at a time; a push or pop that leaves words stored rescans all stored words
// before the response, and the rescan reads one stored word per cycle
// reverse, query, rejected beats and a pop that empties the queue skip the rescan
// reset clears pointers, count, reverse flag and min/max; ram contents are not cleared
// req_stall is high from accept until the response is loaded into the output register;
// a stalled response holds while the next request is already being taken
module reversible_deque_min_max_top #(
   parameter int DEPTH = rdmm_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rdmm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rdmm_pkg::rsp_type rsp_payload
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int WW = rdmm_pkg::WORD_W;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   rdmm_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rev_ff, rev_in;
   logic [1:0]          status_ff, status_in;
   logic signed [WW-1:0] max_ff, max_in, min_ff, min_in;
   logic signed [WW-1:0] hword_ff, hword_in, tword_ff, tword_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [CW-1:0]       off_ff, off_in;
   rdmm_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [WW-1:0]       wr_data;
   logic [AW-1:0]       rd_addr;
   logic [WW-1:0]       rd_data;

   logic                accept, full, empty, at_head, issue;
   logic [AW-1:0]       head_dec, head_inc;
   logic signed [WW-1:0] rd_word;

   rdmm_ram #(
      .WIDTH (WW),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != rdmm_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign rd_addr   = wrap_add(head_ff, idx_ff[AW-1:0]);
   assign rd_word   = $signed(rd_data);
   assign wr_data   = req_payload.value;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rev_in       = rev_ff;
      status_in    = status_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      hword_in     = hword_ff;
      tword_in     = tword_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      off_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = wrap_add(head_ff, count_ff[AW-1:0]);
      at_head      = 1'b0;
      issue        = 1'b0;

      case (state_ff)
         rdmm_pkg::S_IDLE: begin
            if (accept) begin
               status_in = rdmm_pkg::ST_DONE;
               idx_in    = '0;
               state_in  = rdmm_pkg::S_RESP;
               case (req_payload.operation)
                  rdmm_pkg::OP_PUSH_BACK, rdmm_pkg::OP_PUSH_FRONT: begin
                     at_head = (req_payload.operation == rdmm_pkg::OP_PUSH_BACK) ? rev_ff
                                                                                 : !rev_ff;
                     if (full) begin
                        status_in = rdmm_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                        state_in = rdmm_pkg::S_SCAN;
                        if (at_head) begin
                           wr_addr = head_dec;
                           head_in = head_dec;
                        end
                     end
                  end
                  rdmm_pkg::OP_POP_BACK, rdmm_pkg::OP_POP_FRONT: begin
                     at_head = (req_payload.operation == rdmm_pkg::OP_POP_BACK) ? rev_ff
                                                                                : !rev_ff;
                     if (empty) begin
                        status_in = rdmm_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (at_head) begin
                           head_in = head_inc;
                        end
                        if (count_ff == CW'(1)) begin
                           max_in   = '0;
                           min_in   = '0;
                           hword_in = '0;
                           tword_in = '0;
                        end else begin
                           state_in = rdmm_pkg::S_SCAN;
                        end
                     end
                  end
                  rdmm_pkg::OP_REVERSE: begin
                     rev_in = !rev_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end

         rdmm_pkg::S_SCAN: begin
            issue   = (idx_ff < count_ff);
            pend_in = issue;
            off_in  = idx_ff;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (pend_ff) begin
               if (off_ff == '0) begin
                  max_in   = rd_word;
                  min_in   = rd_word;
                  hword_in = rd_word;
               end else begin
                  if (rd_word > max_ff) max_in = rd_word;
                  if (rd_word < min_ff) min_in = rd_word;
               end
               if (off_ff == count_ff - CW'(1)) begin
                  tword_in = rd_word;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = rdmm_pkg::S_RESP;
            end
         end

         rdmm_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.front_value = rev_ff ? tword_ff : hword_ff;
               rsp_in.back_value  = rev_ff ? hword_ff : tword_ff;
               rsp_in.count       = rdmm_pkg::COUNT_W'(count_ff);
               rsp_in.largest     = max_ff;
               rsp_in.smallest    = min_ff;
               rsp_in.is_empty    = empty;
               rsp_in.status      = status_ff;
               rsp_valid_in       = 1'b1;
               state_in           = rdmm_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = rdmm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdmm_pkg::S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         max_ff       <= '0;
         min_ff       <= '0;
         hword_ff     <= '0;
         tword_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         hword_ff     <= hword_in;
         tword_ff     <= tword_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      idx_ff    <= idx_in;
      off_ff    <= off_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
